@@ rtl/core/flu_pkg.sv @@
// Shared types, constants and single-precision arithmetic for the logarithm unit.
// Holds the per-cell operation table; used by flu_front, flu_cell and the top level.
// No dependencies.
package flu_pkg;

    localparam int FLU_CELLS = 31;

    // Logarithm base codes.
    localparam logic [1:0] BASE_LN    = 2'd0;
    localparam logic [1:0] BASE_LG10  = 2'd1;
    localparam logic [1:0] BASE_LG2   = 2'd2;
    localparam logic [1:0] BASE_SPARE = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_NEG    = 2'd2;
    localparam logic [1:0] ST_PASS   = 2'd3;

    // Special bit patterns.
    localparam logic [31:0] F_NEG_INF  = 32'hFF800000;
    localparam logic [31:0] F_POS_INF  = 32'h7F800000;
    localparam logic [31:0] F_QNAN     = 32'h7FC00000;
    localparam logic [31:0] F_NEG_ONE  = 32'hBF800000;
    localparam logic [31:0] F_NEG_HALF = 32'hBF000000;
    localparam logic [22:0] SQRT_HALF_FRAC = 23'h3504F3;

    // Split constants for the exponent terms.
    localparam logic [31:0] LN2_HI   = 32'h3F318000;
    localparam logic [31:0] LN2_LO   = 32'hB95E8083;
    localparam logic [31:0] LG2_HI   = 32'h3E9A0000;
    localparam logic [31:0] LG2_LO   = 32'h39826A14;
    localparam logic [31:0] LGE_HI   = 32'h3EDE0000;
    localparam logic [31:0] LGE_LO   = 32'h3A37B152;
    localparam logic [31:0] LOG2E_M1 = 32'h3EE2A8ED;

    // Polynomial coefficients, constant term first.
    localparam logic [31:0] POLY_COEF [0:8] = '{
        32'h3EAAAAAA, 32'hBE7FFFFC, 32'h3E4CCEAC, 32'hBE2AAE50, 32'h3E11E9BF,
        32'hBDFE5D4F, 32'h3DEF251A, 32'hBDEBD1B8, 32'h3D9021BB
    };

    typedef enum logic [1:0] {OP_NOP, OP_MUL, OP_ADD} flu_op_e;
    typedef enum logic [2:0] {SRC_T, SRC_Z, SRC_FE, SRC_P, SRC_Y, SRC_R, SRC_M, SRC_K} flu_src_e;
    typedef enum logic [2:0] {DST_Z, DST_P, DST_Y, DST_R, DST_M} flu_dst_e;

    typedef struct packed {
        flu_op_e     op;
        flu_src_e    src_a;
        flu_src_e    src_b;
        flu_dst_e    dst;
        logic [31:0] k;
        logic        cond;
    } flu_uop_t;

    typedef struct packed {
        logic [1:0]  base;
        logic        spec;
        logic [1:0]  status;
        logic [31:0] r;
        logic [31:0] f;
        logic [8:0]  e;
    } flu_split_t;

    typedef struct packed {
        logic [1:0]  base;
        logic        spec;
        logic [1:0]  status;
        logic        e_nz;
        logic [31:0] t;
        logic [31:0] z;
        logic [31:0] fe;
        logic [31:0] p;
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] m;
    } flu_ctx_t;

    // Round-to-nearest-even multiply. Operands are normal or zero; in this unit
    // no product leaves the normal range.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sign;
        logic [47:0] prod;
        logic [23:0] mant;
        logic        g;
        logic        s;
        logic        inc;
        logic [24:0] rnd;
        logic [10:0] ex;
        logic [31:0] res;
        sign = a[31] ^ b[31];
        prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        ex   = {3'b0, a[30:23]} + {3'b0, b[30:23]} - 11'd127;
        if (prod[47])
        begin
            mant = prod[47:24];
            g    = prod[23];
            s    = |prod[22:0];
            ex   = ex + 11'd1;
        end
        else
        begin
            mant = prod[46:23];
            g    = prod[22];
            s    = |prod[21:0];
        end
        inc = g & (s | mant[0]);
        rnd = {1'b0, mant} + {24'b0, inc};
        if (rnd[24])
        begin
            ex  = ex + 11'd1;
            res = {sign, ex[7:0], 23'b0};
        end
        else
        begin
            res = {sign, ex[7:0], rnd[22:0]};
        end
        if (a[30:23] == 8'd0 || b[30:23] == 8'd0)
        begin
            res = {sign, 31'b0};
        end
        return res;
    endfunction

    // Round-to-nearest-even add with guard, round and sticky bits.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        swap;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  d8;
        logic [4:0]  d;
        logic [27:0] mb;
        logic [27:0] ms;
        logic [27:0] sh;
        logic [27:0] sum;
        logic [26:0] nrm;
        logic [4:0]  lz;
        logic [9:0]  ex;
        logic        inc;
        logic [24:0] rnd;
        logic [31:0] res;
        swap = b[30:0] > a[30:0];
        big  = swap ? b : a;
        sml  = swap ? a : b;
        d8   = big[30:23] - sml[30:23];
        d    = (d8 > 8'd27) ? 5'd27 : d8[4:0];
        mb   = {2'b01, big[22:0], 3'b0};
        ms   = {2'b01, sml[22:0], 3'b0};
        sh   = ms >> d;
        sh[0] = sh[0] | (|(ms & ~(28'hFFFFFFF << d)));
        sum  = (a[31] ^ b[31]) ? (mb - sh) : (mb + sh);
        ex   = {2'b0, big[30:23]};
        lz   = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (sum[i])
            begin
                lz = 5'(26 - i);
            end
        end
        if (sum[27])
        begin
            nrm = {sum[27:2], sum[1] | sum[0]};
            ex  = ex + 10'd1;
        end
        else
        begin
            nrm = sum[26:0] << lz;
            ex  = ex - {5'b0, lz};
        end
        inc = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
        rnd = {1'b0, nrm[26:3]} + {24'b0, inc};
        if (rnd[24])
        begin
            ex  = ex + 10'd1;
            res = {big[31], ex[7:0], 23'b0};
        end
        else
        begin
            res = {big[31], ex[7:0], rnd[22:0]};
        end
        if (sum == 28'd0)
        begin
            res = 32'd0;
        end
        if (a[30:23] == 8'd0 && b[30:23] == 8'd0)
        begin
            res = {a[31] & b[31], 31'b0};
        end
        else if (a[30:23] == 8'd0)
        begin
            res = b;
        end
        else if (b[30:23] == 8'd0)
        begin
            res = a;
        end
        return res;
    endfunction

    // Exact conversion of a small signed exponent to single precision.
    function automatic logic [31:0] int_to_float(input logic [8:0] e);
        logic [8:0]  neg;
        logic [7:0]  mag;
        logic [2:0]  k;
        logic [30:0] wide;
        neg  = -e;
        mag  = e[8] ? neg[7:0] : e[7:0];
        k    = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mag[i])
            begin
                k = 3'(i);
            end
        end
        wide = {23'b0, mag} << (5'd23 - {2'b0, k});
        return (e == 9'd0) ? 32'd0 : {e[8], 8'd127 + {5'b0, k}, wide[22:0]};
    endfunction

    function automatic flu_uop_t mk(input flu_op_e op, input flu_src_e a, input flu_src_e b,
                                    input flu_dst_e dst, input logic [31:0] k,
                                    input logic cond);
        flu_uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = dst;
        u.k     = k;
        u.cond  = cond;
        return u;
    endfunction

    // Operation of each cell: squaring, the Horner steps, then the base-specific tail.
    function automatic flu_uop_t flu_uop(input int step, input logic [1:0] base);
        flu_uop_t u;
        u = mk(OP_NOP, SRC_T, SRC_T, DST_M, 32'd0, 1'b0);
        if (step == 0)
        begin
            u = mk(OP_MUL, SRC_T, SRC_T, DST_Z, 32'd0, 1'b0);
        end
        else if (step <= 16)
        begin
            if (step % 2 == 1)
            begin
                u = mk(OP_MUL, SRC_P, SRC_T, DST_P, 32'd0, 1'b0);
            end
            else
            begin
                u = mk(OP_ADD, SRC_P, SRC_K, DST_P, POLY_COEF[8 - step / 2], 1'b0);
            end
        end
        else if (base == BASE_LG10)
        begin
            case (step)
                17: u = mk(OP_MUL, SRC_Z, SRC_P, DST_M, 32'd0, 1'b0);
                18: u = mk(OP_MUL, SRC_T, SRC_M, DST_Y, 32'd0, 1'b0);
                19: u = mk(OP_MUL, SRC_Z, SRC_K, DST_M, F_NEG_HALF, 1'b0);
                20: u = mk(OP_ADD, SRC_Y, SRC_M, DST_Y, 32'd0, 1'b0);
                21: u = mk(OP_ADD, SRC_T, SRC_Y, DST_R, 32'd0, 1'b0);
                22: u = mk(OP_MUL, SRC_R, SRC_K, DST_R, LGE_LO, 1'b0);
                23: u = mk(OP_MUL, SRC_Y, SRC_K, DST_M, LGE_HI, 1'b0);
                24: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b0);
                25: u = mk(OP_MUL, SRC_T, SRC_K, DST_M, LGE_HI, 1'b0);
                26: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b0);
                27: u = mk(OP_MUL, SRC_FE, SRC_K, DST_M, LG2_LO, 1'b0);
                28: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b0);
                29: u = mk(OP_MUL, SRC_FE, SRC_K, DST_M, LG2_HI, 1'b0);
                30: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b0);
                default: u = mk(OP_NOP, SRC_T, SRC_T, DST_M, 32'd0, 1'b0);
            endcase
        end
        else if (base == BASE_LG2)
        begin
            case (step)
                17: u = mk(OP_MUL, SRC_Z, SRC_P, DST_M, 32'd0, 1'b0);
                18: u = mk(OP_MUL, SRC_T, SRC_M, DST_Y, 32'd0, 1'b0);
                19: u = mk(OP_MUL, SRC_Z, SRC_K, DST_M, F_NEG_HALF, 1'b0);
                20: u = mk(OP_ADD, SRC_Y, SRC_M, DST_Y, 32'd0, 1'b0);
                21: u = mk(OP_MUL, SRC_Y, SRC_K, DST_R, LOG2E_M1, 1'b0);
                22: u = mk(OP_MUL, SRC_T, SRC_K, DST_M, LOG2E_M1, 1'b0);
                23: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b0);
                24: u = mk(OP_ADD, SRC_R, SRC_Y, DST_R, 32'd0, 1'b0);
                25: u = mk(OP_ADD, SRC_R, SRC_T, DST_R, 32'd0, 1'b0);
                26: u = mk(OP_ADD, SRC_R, SRC_FE, DST_R, 32'd0, 1'b0);
                default: u = mk(OP_NOP, SRC_T, SRC_T, DST_M, 32'd0, 1'b0);
            endcase
        end
        else
        begin
            case (step)
                17: u = mk(OP_MUL, SRC_P, SRC_T, DST_Y, 32'd0, 1'b0);
                18: u = mk(OP_MUL, SRC_Y, SRC_Z, DST_Y, 32'd0, 1'b0);
                19: u = mk(OP_MUL, SRC_FE, SRC_K, DST_M, LN2_LO, 1'b0);
                20: u = mk(OP_ADD, SRC_Y, SRC_M, DST_Y, 32'd0, 1'b1);
                21: u = mk(OP_MUL, SRC_Z, SRC_K, DST_M, F_NEG_HALF, 1'b0);
                22: u = mk(OP_ADD, SRC_Y, SRC_M, DST_Y, 32'd0, 1'b0);
                23: u = mk(OP_ADD, SRC_T, SRC_Y, DST_R, 32'd0, 1'b0);
                24: u = mk(OP_MUL, SRC_FE, SRC_K, DST_M, LN2_HI, 1'b0);
                25: u = mk(OP_ADD, SRC_R, SRC_M, DST_R, 32'd0, 1'b1);
                default: u = mk(OP_NOP, SRC_T, SRC_T, DST_M, 32'd0, 1'b0);
            endcase
        end
        return u;
    endfunction

    function automatic logic [31:0] flu_pick(input flu_ctx_t c, input flu_src_e s,
                                             input logic [31:0] k);
        logic [31:0] v;
        case (s)
            SRC_T:   v = c.t;
            SRC_Z:   v = c.z;
            SRC_FE:  v = c.fe;
            SRC_P:   v = c.p;
            SRC_Y:   v = c.y;
            SRC_R:   v = c.r;
            SRC_M:   v = c.m;
            SRC_K:   v = k;
            default: v = k;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/flu_front.sv @@
// Front end of the logarithm unit: special-case screening, exponent/fraction split.
// Two pipeline stages; depends on flu_pkg.
module flu_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [31:0]       x_bits,
    input  logic [1:0]        base,
    output logic              dn_valid,
    input  logic              dn_ready,
    output flu_pkg::flu_ctx_t dn_ctx
);

    logic                 a_valid_reg;
    logic                 a_ready;
    flu_pkg::flu_split_t  a_reg;
    flu_pkg::flu_split_t  a_next;
    logic                 b_valid_reg;
    flu_pkg::flu_ctx_t    b_reg;
    flu_pkg::flu_ctx_t    b_next;

    logic [30:0] mag;
    logic [22:0] mant;
    logic [22:0] mant2;
    logic [4:0]  p;
    logic [8:0]  e;

    always_comb
    begin
        mag  = x_bits[30:0];
        mant = x_bits[22:0];
        p    = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (mant[i])
            begin
                p = 5'(i);
            end
        end
        if (x_bits[30:23] == 8'd0)
        begin
            mant2 = mant << (5'd23 - p);
            e     = {4'b0, p} - 9'd148;
        end
        else
        begin
            mant2 = mant;
            e     = {1'b0, x_bits[30:23]} - 9'd126;
        end
        a_next.base   = base;
        a_next.spec   = 1'b1;
        a_next.status = flu_pkg::ST_NORMAL;
        a_next.r      = x_bits;
        if (mant2 < flu_pkg::SQRT_HALF_FRAC)
        begin
            a_next.e = e - 9'd1;
            a_next.f = {1'b0, 8'd127, mant2};
        end
        else
        begin
            a_next.e = e;
            a_next.f = {1'b0, 8'd126, mant2};
        end
        if (mag > 31'h7F800000)
        begin
            a_next.status = flu_pkg::ST_PASS;
        end
        else if (mag == 31'd0)
        begin
            a_next.r      = flu_pkg::F_NEG_INF;
            a_next.status = flu_pkg::ST_ZERO;
        end
        else if (x_bits[31])
        begin
            a_next.r      = flu_pkg::F_QNAN;
            a_next.status = flu_pkg::ST_NEG;
        end
        else if (mag == 31'h7F800000)
        begin
            a_next.status = flu_pkg::ST_PASS;
        end
        else
        begin
            a_next.spec = 1'b0;
        end
    end

    always_comb
    begin
        b_next.base   = a_reg.base;
        b_next.spec   = a_reg.spec;
        b_next.status = a_reg.status;
        b_next.e_nz   = (a_reg.e != 9'd0);
        b_next.t      = flu_pkg::fp_add(a_reg.f, flu_pkg::F_NEG_ONE);
        b_next.z      = 32'd0;
        b_next.fe     = flu_pkg::int_to_float(a_reg.e);
        b_next.p      = flu_pkg::POLY_COEF[8];
        b_next.y      = 32'd0;
        b_next.r      = a_reg.r;
        b_next.m      = 32'd0;
    end

    assign a_ready  = !b_valid_reg || dn_ready;
    assign up_ready = !a_valid_reg || a_ready;
    assign dn_valid = b_valid_reg;
    assign dn_ctx   = b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            a_reg <= a_next;
        end
        if (a_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

@@ rtl/core/flu_cell.sv @@
// One cell of the arithmetic chain: at most one rounded multiply or add per item.
// Depends on flu_pkg for the context type, the operation table and the float ops.
module flu_cell #(
    parameter int STEP = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  flu_pkg::flu_ctx_t up_ctx,
    output logic              dn_valid,
    input  logic              dn_ready,
    output flu_pkg::flu_ctx_t dn_ctx
);

    logic              valid_reg;
    flu_pkg::flu_ctx_t ctx_reg;
    flu_pkg::flu_ctx_t ctx_next;
    flu_pkg::flu_uop_t uop;
    logic [31:0]       opa;
    logic [31:0]       opb;
    logic [31:0]       res;

    always_comb
    begin
        uop      = flu_pkg::flu_uop(STEP, up_ctx.base);
        opa      = flu_pkg::flu_pick(up_ctx, uop.src_a, uop.k);
        opb      = flu_pkg::flu_pick(up_ctx, uop.src_b, uop.k);
        res      = (uop.op == flu_pkg::OP_MUL) ? flu_pkg::fp_mul(opa, opb)
                                               : flu_pkg::fp_add(opa, opb);
        ctx_next = up_ctx;
        // Special items carry their final value in r and skip all arithmetic.
        if (uop.op != flu_pkg::OP_NOP && !up_ctx.spec && (!uop.cond || up_ctx.e_nz))
        begin
            case (uop.dst)
                flu_pkg::DST_Z: ctx_next.z = res;
                flu_pkg::DST_P: ctx_next.p = res;
                flu_pkg::DST_Y: ctx_next.y = res;
                flu_pkg::DST_R: ctx_next.r = res;
                flu_pkg::DST_M: ctx_next.m = res;
                default:        ctx_next.m = res;
            endcase
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_ctx   = ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

@@ rtl/core/float_logarithm_unit.sv @@
// Single-precision logarithm unit, base e, ten or two.
// Pipeline: 33 registers (2 front stages, 31 cells) from the input to the output port.
// Throughput: one item per cycle; every stage holds one item and moves it on as
// soon as the next stage has room, so stalls at the output only fill bubbles.
// Reset: rst_n clears all valid bits and sets the base register to natural log.
module float_logarithm_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  base_select,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] x_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] y_bits,
    output logic [1:0]  status
);

    // The base register is to be written only while the unit is idle; the block does
    // not enforce it. Each item takes a copy of the base when it enters, so the chain needs no global control.
    logic [1:0] base_reg;
    logic [1:0] base_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= flu_pkg::BASE_LN;
        end
        else if (cfg_valid)
        begin
            base_reg <= base_select;
        end
    end

    // The unused base code falls back to the natural logarithm.
    assign base_item = (base_reg == flu_pkg::BASE_SPARE) ? flu_pkg::BASE_LN : base_reg;

    // Chain links: index 0 is the front end's output, the last one feeds the port.
    logic              link_valid [0:flu_pkg::FLU_CELLS];
    logic              link_ready [0:flu_pkg::FLU_CELLS];
    flu_pkg::flu_ctx_t link_ctx   [0:flu_pkg::FLU_CELLS];

    // The front end screens special values, splits the argument into exponent and
    // folded fraction, and forms t and the exponent as a float.
    flu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .x_bits   (x_bits),
        .base     (base_item),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_ctx   (link_ctx[0])
    );

    // Each cell performs at most one rounded operation: first t*t, then the eight
    // Horner steps of the polynomial, then the base-specific tail with the exponent
    // (split constants for base e and ten). Each op rounds exactly as one float op.
    for (genvar i = 0; i < flu_pkg::FLU_CELLS; i++)
    begin : g_cell
        flu_cell #(
            .STEP (i)
        ) u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_ctx   (link_ctx[i]),
            .dn_valid (link_valid[i + 1]),
            .dn_ready (link_ready[i + 1]),
            .dn_ctx   (link_ctx[i + 1])
        );
    end

    // The last cell's register is the output register; special items carry their
    // final pattern in r from the front end on.
    assign out_valid                     = link_valid[flu_pkg::FLU_CELLS];
    assign link_ready[flu_pkg::FLU_CELLS] = out_ready;
    assign y_bits                        = link_ctx[flu_pkg::FLU_CELLS].r;
    assign status                        = link_ctx[flu_pkg::FLU_CELLS].status;

endmodule
